### hdl/dpuh_pkg.sv
package dpuh_pkg;

  localparam int UNIT_W        = 16;
  localparam int HASH_W        = 32;
  localparam int UID_W         = 41;
  localparam int TEXT_W        = 64;
  localparam int MAX_UNITS_DEF = 128;

  localparam int SEED131_TAP   = 23;
  localparam int TOP_BITS      = HASH_W - SEED131_TAP;

  localparam int RADIX         = 36;
  localparam int NUM_DIGITS    = 8;
  localparam int DIGIT_CNT_W   = $clog2(NUM_DIGITS);
  localparam int CHUNK_W       = 6;
  localparam int NUM_CHUNKS    = (UID_W + CHUNK_W - 1) / CHUNK_W;
  localparam int CHUNK_CNT_W   = $clog2(NUM_CHUNKS);
  localparam int DIV_W         = NUM_CHUNKS * CHUNK_W;
  localparam int PART_W        = 2 * CHUNK_W;

  // floor(x / 36) == (x * 1821) >> 16 for every x below 36 * 64
  localparam int RECIP_W       = 11;
  localparam int RECIP_SHIFT   = 16;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(1821);
  localparam int PROD_W        = PART_W + RECIP_W;

  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_LETTER = 8'h37;
  localparam logic [CHUNK_W-1:0] TEN = CHUNK_W'(10);

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  function automatic logic [7:0] digit_char(input logic [CHUNK_W-1:0] d);
    logic [7:0] ch;
    if (d < TEN) begin
      ch = CHAR_ZERO + {2'b00, d};
    end else begin
      ch = CHAR_LETTER + {2'b00, d};
    end
    return ch;
  endfunction

endpackage

### hdl/dpuh_front.sv
module dpuh_front
  import dpuh_pkg::*;
#(
  parameter int MAX_UNITS = MAX_UNITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              unit_valid,
  output logic              unit_stall,
  input  logic [UNIT_W-1:0] code_unit,
  input  queue_status_t     queue_status,
  output logic              push,
  output logic [UID_W-1:0]  push_uid
);

  localparam int CNT_W = $clog2(MAX_UNITS + 1);

  logic [HASH_W-1:0] acc31;
  logic [HASH_W-1:0] acc131;
  logic [CNT_W-1:0]  count;
  logic [HASH_W-1:0] acc31_next;
  logic [HASH_W-1:0] acc131_next;
  logic [HASH_W-1:0] unit_ext;
  logic              accept;
  logic              is_term;

  assign unit_stall = queue_status.full;
  assign accept     = unit_valid && !unit_stall;
  assign is_term    = (code_unit == '0);
  assign unit_ext   = {{(HASH_W - UNIT_W){1'b0}}, code_unit};

  // times 31 and times 131 as shift-add
  assign acc31_next  = (acc31 << 5) - acc31 + unit_ext;
  assign acc131_next = (acc131 << 7) + (acc131 << 1) + acc131 + unit_ext;

  assign push     = accept && is_term;
  assign push_uid = {acc31, acc131[HASH_W-1:SEED131_TAP]};

  always_ff @(posedge clk) begin
    if (rst) begin
      acc31  <= '0;
      acc131 <= '0;
      count  <= '0;
    end else if (accept) begin
      if (is_term) begin
        acc31  <= '0;
        acc131 <= '0;
        count  <= '0;
      end else if (count < CNT_W'(MAX_UNITS)) begin
        acc31  <= acc31_next;
        acc131 <= acc131_next;
        count  <= count + 1'b1;
      end
    end
  end

endmodule

### hdl/dpuh_queue.sv
module dpuh_queue
  import dpuh_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [UID_W-1:0] push_uid,
  input  logic             pop,
  output logic [UID_W-1:0] pop_uid,
  output queue_status_t    status
);

  logic [UID_W-1:0]  mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;

  assign status.full  = (fill == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign status.empty = (fill == '0);
  assign pop_uid      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_uid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && status.full))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && status.empty))
    else $error("queue read while empty");
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
      fill <= (QPTR_W + 1)'(QUEUE_DEPTH))
    else $error("queue fill count out of range");

endmodule

### hdl/dpuh_back.sv
module dpuh_back
  import dpuh_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  queue_status_t     queue_status,
  output logic              pop,
  input  logic [UID_W-1:0]  pop_uid,
  output logic              uid_valid,
  input  logic              uid_stall,
  output logic [UID_W-1:0]  uid_value,
  output logic [TEXT_W-1:0] uid_text
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_CONV = 2'b10
  } state_t;

  state_t                 state;
  logic [UID_W-1:0]       uid;
  logic [DIV_W-1:0]       dividend;
  logic [DIV_W-1:0]       quotient;
  logic [CHUNK_W-1:0]     rem;
  logic [CHUNK_CNT_W-1:0] chunk;
  logic [DIGIT_CNT_W-1:0] digit;
  logic [TEXT_W-1:0]      text;

  logic [PART_W-1:0]      part;
  logic [PROD_W-1:0]      prod;
  logic [CHUNK_W-1:0]     q;
  logic [PART_W-1:0]      q_times;
  logic [PART_W-1:0]      r_wide;
  logic [CHUNK_W-1:0]     r;
  logic [DIV_W-1:0]       quotient_next;
  logic                   last_chunk;
  logic                   last_step;
  logic                   out_free;
  logic                   advance;

  // one six-bit step of long division by 36
  assign part          = {rem, dividend[DIV_W-1 -: CHUNK_W]};
  assign prod          = {{RECIP_W{1'b0}}, part} * {{PART_W{1'b0}}, RECIP};
  assign q             = prod[RECIP_SHIFT +: CHUNK_W];
  assign q_times       = ({{CHUNK_W{1'b0}}, q} << 5) + ({{CHUNK_W{1'b0}}, q} << 2);
  assign r_wide        = part - q_times;
  assign r             = r_wide[CHUNK_W-1:0];
  assign quotient_next = {quotient[DIV_W-CHUNK_W-1:0], q};

  assign last_chunk = (chunk == CHUNK_CNT_W'(NUM_CHUNKS - 1));
  assign last_step  = last_chunk && (digit == DIGIT_CNT_W'(NUM_DIGITS - 1));
  assign out_free   = !uid_valid || !uid_stall;
  assign advance    = (state == S_CONV) && (!last_step || out_free);
  assign pop        = (state == S_IDLE) && !queue_status.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (pop) begin
            state <= S_CONV;
          end
        end
        S_CONV: begin
          if (advance && last_step) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk <= '0;
      digit <= '0;
    end else if (pop) begin
      chunk <= '0;
      digit <= '0;
    end else if (advance) begin
      if (last_chunk) begin
        chunk <= '0;
        digit <= digit + 1'b1;
      end else begin
        chunk <= chunk + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      uid      <= pop_uid;
      dividend <= {{(DIV_W - UID_W){1'b0}}, pop_uid};
      quotient <= '0;
      rem      <= '0;
    end else if (advance) begin
      if (last_chunk) begin
        dividend <= quotient_next;
        quotient <= '0;
        rem      <= '0;
        text     <= {digit_char(r), text[TEXT_W-1:8]};
      end else begin
        dividend <= dividend << CHUNK_W;
        quotient <= quotient_next;
        rem      <= r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      uid_valid <= 1'b0;
    end else if (advance && last_step) begin
      uid_valid <= 1'b1;
    end else if (!uid_stall) begin
      uid_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && last_step) begin
      uid_value <= uid;
      uid_text  <= {digit_char(r), text[TEXT_W-1:8]};
    end
  end

  a_rem_range: assert property (@(posedge clk) disable iff (rst)
      (state == S_CONV) |-> (rem < CHUNK_W'(RADIX)))
    else $error("division remainder out of range");
  a_chunk_range: assert property (@(posedge clk) disable iff (rst)
      chunk <= CHUNK_CNT_W'(NUM_CHUNKS - 1))
    else $error("chunk counter out of range");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
      (uid_valid && uid_stall) |=> uid_valid)
    else $error("waiting transaction dropped");

endmodule

### hdl/dual_polynomial_uid_hash.sv
// Hashes a string of 16-bit code units, one unit a cycle, ended by a zero unit.
// Two 32-bit wrapping hashes (times 31 and times 131) run over the first
// MAX_UNITS units; later units are ignored. Each terminator yields one
// transaction: a 41-bit identifier and the same value as eight uppercase
// base-36 ASCII digits. Identifiers pass through a 4-entry queue to a base-36
// formatter that does a long division by 36 six bits a cycle: 7 steps per
// digit, 8 digits, plus a load step per identifier. While uid_stall is low,
// strings of 56 units or more stream at one unit a cycle; shorter strings back
// up into the queue and the unit channel stalls once it is full.
module dual_polynomial_uid_hash
  import dpuh_pkg::*;
#(
  parameter int MAX_UNITS = MAX_UNITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              unit_valid,
  output logic              unit_stall,
  input  logic [UNIT_W-1:0] code_unit,
  output logic              uid_valid,
  input  logic              uid_stall,
  output logic [UID_W-1:0]  uid_value,
  output logic [TEXT_W-1:0] uid_text
);

  queue_status_t    queue_status;
  logic             push;
  logic [UID_W-1:0] push_uid;
  logic             pop;
  logic [UID_W-1:0] pop_uid;

  dpuh_front #(
    .MAX_UNITS(MAX_UNITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .unit_valid  (unit_valid),
    .unit_stall  (unit_stall),
    .code_unit   (code_unit),
    .queue_status(queue_status),
    .push        (push),
    .push_uid    (push_uid)
  );

  dpuh_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_uid(push_uid),
    .pop     (pop),
    .pop_uid (pop_uid),
    .status  (queue_status)
  );

  dpuh_back u_back (
    .clk         (clk),
    .rst         (rst),
    .queue_status(queue_status),
    .pop         (pop),
    .pop_uid     (pop_uid),
    .uid_valid   (uid_valid),
    .uid_stall   (uid_stall),
    .uid_value   (uid_value),
    .uid_text    (uid_text)
  );

endmodule

### dv/uid_hash_checker.sv
module uid_hash_checker
  import dpuh_pkg::*;
#(
  parameter int MAX_UNITS = MAX_UNITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              unit_valid,
  input  logic              unit_stall,
  input  logic [UNIT_W-1:0] code_unit,
  input  logic              uid_valid,
  input  logic              uid_stall,
  input  logic [UID_W-1:0]  uid_value,
  input  logic [TEXT_W-1:0] uid_text,
  output int                fail_count,
  output int                ids_checked,
  output int                ids_pending
);

  typedef struct packed {
    logic [UID_W-1:0]  value;
    logic [TEXT_W-1:0] text;
  } uid_record_t;

  localparam logic [HASH_W-1:0] MULT_A     = HASH_W'(31);
  localparam logic [HASH_W-1:0] MULT_B     = HASH_W'(131);
  localparam int                DEC_DIGITS = 10;
  localparam logic [7:0]        ASCII_ZERO = 8'h30;
  localparam logic [7:0]        ASCII_A    = 8'h41;

  logic [HASH_W-1:0] hash31;
  logic [HASH_W-1:0] hash131;
  int unsigned       units_hashed;
  uid_record_t       expected_ids[$];

  function automatic logic [TEXT_W-1:0] base36_text(input logic [UID_W-1:0] v);
    logic [UID_W-1:0]  rest;
    logic [UID_W-1:0]  d;
    logic [TEXT_W-1:0] text;
    rest = v;
    text = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      d = rest % RADIX;
      rest = rest / RADIX;
      if (d < DEC_DIGITS) begin
        text[8*i +: 8] = ASCII_ZERO + 8'(d);
      end else begin
        text[8*i +: 8] = ASCII_A + 8'(d - DEC_DIGITS);
      end
    end
    return text;
  endfunction

  always @(posedge clk) begin
    uid_record_t      want;
    logic [UID_W-1:0] uid;
    if (rst) begin
      hash31 = '0;
      hash131 = '0;
      units_hashed = 0;
      expected_ids.delete();
      fail_count = 0;
      ids_checked = 0;
    end else begin
      if (unit_valid && !unit_stall) begin
        if (code_unit != '0) begin
          // units past the limit leave both hashes alone
          if (units_hashed < MAX_UNITS) begin
            hash31 = hash31 * MULT_A + HASH_W'(code_unit);
            hash131 = hash131 * MULT_B + HASH_W'(code_unit);
            units_hashed++;
          end
        end else begin
          uid = {hash31, hash131[HASH_W-1 -: TOP_BITS]};
          want.value = uid;
          want.text = base36_text(uid);
          expected_ids.push_back(want);
          hash31 = '0;
          hash131 = '0;
          units_hashed = 0;
        end
      end
      if (uid_valid && !uid_stall) begin
        if (expected_ids.size() == 0) begin
          $error("unexpected uid transaction: uid_value %h uid_text %h", uid_value, uid_text);
          fail_count++;
        end else begin
          want = expected_ids.pop_front();
          ids_checked++;
          if (uid_value !== want.value) begin
            $error("uid_value mismatch: expected %h, got %h", want.value, uid_value);
            fail_count++;
          end
          if (uid_text !== want.text) begin
            $error("uid_text mismatch: expected %h, got %h", want.text, uid_text);
            fail_count++;
          end
        end
      end
    end
    ids_pending <= expected_ids.size();
  end

endmodule

### dv/tb_dual_polynomial_uid_hash.sv
module tb_dual_polynomial_uid_hash;
  import dpuh_pkg::*;

  typedef enum int {STALL_NONE, STALL_HALF, STALL_HEAVY, STALL_ALT} stall_mode_t;

  localparam int RANDOM_UNITS = 800;
  localparam int TAIL_CYCLES  = 300;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              unit_valid = 1'b0;
  logic              unit_stall;
  logic [UNIT_W-1:0] code_unit = '0;
  logic              uid_valid;
  logic              uid_stall = 1'b0;
  logic [UID_W-1:0]  uid_value;
  logic [TEXT_W-1:0] uid_text;

  int fail_count;
  int ids_checked;
  int ids_pending;

  int          burst_left = 0;
  int          units_sent = 0;
  int          strings_sent = 0;
  int          overlong_sent = 0;
  int          stall_left = 0;
  stall_mode_t stall_mode = STALL_NONE;

  always #4 clk = ~clk;

  dual_polynomial_uid_hash dut (
    .clk        (clk),
    .rst        (rst),
    .unit_valid (unit_valid),
    .unit_stall (unit_stall),
    .code_unit  (code_unit),
    .uid_valid  (uid_valid),
    .uid_stall  (uid_stall),
    .uid_value  (uid_value),
    .uid_text   (uid_text)
  );

  uid_hash_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .unit_valid  (unit_valid),
    .unit_stall  (unit_stall),
    .code_unit   (code_unit),
    .uid_valid   (uid_valid),
    .uid_stall   (uid_stall),
    .uid_value   (uid_value),
    .uid_text    (uid_text),
    .fail_count  (fail_count),
    .ids_checked (ids_checked),
    .ids_pending (ids_pending)
  );

  // receiver back-pressure, switching between modes
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      stall_left <= $urandom_range(10, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE:  uid_stall <= 1'b0;
      STALL_HALF:  uid_stall <= 1'($urandom_range(0, 1));
      STALL_HEAVY: uid_stall <= ($urandom_range(0, 7) != 0);
      STALL_ALT:   uid_stall <= ~uid_stall;
      default:     uid_stall <= 1'b0;
    endcase
  end

  task automatic send_unit(input logic [UNIT_W-1:0] v);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        unit_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 60);
    end
    unit_valid <= 1'b1;
    code_unit <= v;
    do @(posedge clk); while (unit_stall);
    @(negedge clk);
    burst_left--;
    units_sent++;
    if (v == '0) strings_sent++;
  endtask

  function automatic logic [UNIT_W-1:0] rand_unit();
    logic [UNIT_W-1:0] u;
    case ($urandom_range(0, 3))
      0:       u = UNIT_W'($urandom_range(32, 126));
      1:       u = UNIT_W'(1) << $urandom_range(0, UNIT_W - 1);
      2:       u = '1;
      default: u = UNIT_W'($urandom_range(1, 65535));
    endcase
    return u;
  endfunction

  task automatic send_string(input int len);
    for (int i = 0; i < len; i++) send_unit(rand_unit());
    send_unit('0);
  endtask

  initial begin
    int len;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty strings, back to back, then short strings of one to four units
    send_unit('0);
    send_unit('0);
    send_unit(16'h0041);
    send_unit('0);
    send_unit(16'hFFFF);
    send_unit('0);
    send_unit(16'h0001);
    send_unit(16'h8000);
    send_unit(16'h5555);
    send_unit(16'hAAAA);
    send_unit('0);
    send_unit(16'h7FFF);
    send_unit(16'hFFFE);
    send_unit('0);
    // overlong string, then one of exactly the limit
    for (int i = 0; i < MAX_UNITS_DEF + 1; i++) send_unit(16'hFFFF);
    send_unit('0);
    overlong_sent++;
    send_string(MAX_UNITS_DEF);

    while (units_sent < RANDOM_UNITS) begin
      case ($urandom_range(0, 19))
        0, 1:    len = 0;
        2:       len = $urandom_range(MAX_UNITS_DEF - 8, MAX_UNITS_DEF + 12);
        default: len = $urandom_range(1, 12);
      endcase
      if (len > MAX_UNITS_DEF) overlong_sent++;
      send_string(len);
    end
    unit_valid <= 1'b0;

    while (ids_pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("sent %0d code units in %0d strings (%0d overlong), checked %0d identifiers",
             units_sent, strings_sent, overlong_sent, ids_checked);
    $display("receiver stalls mixed none, half, heavy and alternating patterns");
    if (fail_count == 0 && ids_pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
